### sv/dwt_periodic_analysis_line_macros.svh
// Assertion macros shared by the periodic wavelet analysis line RTL.
`ifndef DWT_PERIODIC_ANALYSIS_LINE_MACROS_SVH
`define DWT_PERIODIC_ANALYSIS_LINE_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define DPAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define DPAL_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define DPAL_ASSERT(lbl, prop, msg)
`define DPAL_NEVER(lbl, expr, msg)
`endif
`endif

### sv/dpal_pkg.sv
// Constants, codes and controller/datapath interface types for the analysis line.
package dpal_pkg;

  localparam int MAX_TAPS      = 8;
  localparam int LINE_MAX      = 1024;
  localparam int SAMPLE_WIDTH  = 16;
  localparam int TAP_FRAC_BITS = 14;

  localparam int TAP_W       = 16;
  localparam int TAP_IDX_W   = $clog2(MAX_TAPS);
  localparam int TAP_CNT_W   = $clog2(MAX_TAPS + 1);
  localparam int POS_W       = $clog2(LINE_MAX);
  localparam int LEN_W       = POS_W + 1;
  localparam int PROD_W      = SAMPLE_WIDTH + TAP_W;
  localparam int HALF_TAPS   = MAX_TAPS / 2;
  localparam int S1_W        = PROD_W + 1;
  localparam int ACC_W       = PROD_W + TAP_IDX_W;
  localparam int COEF_W      = 20;
  localparam int COEF_MAX    = 524287;
  localparam int COEF_MIN    = -524288;
  localparam int BAND_W      = 2;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  localparam int IN_TDATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((COEF_W + POS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - COEF_W - POS_W;
  localparam int OUT_TUSER_W = BAND_W + 1;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TAP_COUNT        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_LENGTH      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_TAPS_FIRST   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_TAPS_SECOND  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_TAPS_FIRST  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_TAPS_SECOND = 3'd5;

  // band codes
  localparam logic [BAND_W-1:0] BAND_LOW  = 2'd0;
  localparam logic [BAND_W-1:0] BAND_HIGH = 2'd1;
  localparam logic [BAND_W-1:0] BAND_PASS = 2'd2;

  // output register source select
  localparam logic [1:0] OUT_LO    = 2'd0;
  localparam logic [1:0] OUT_HI    = 2'd1;
  localparam logic [1:0] OUT_TRAIL = 2'd2;

  typedef struct packed {
    logic       accept;
    logic       pair_init;
    logic       gather;
    logic       next_pair;
    logic       load_out;
    logic [1:0] out_sel;
  } dpal_cmd_t;

  typedef struct packed {
    logic pair_pending;
    logic trailing;
    logic gather_last;
    logic out_free;
  } dpal_status_t;

endpackage

### sv/dpal_ctrl.sv
// Sequencer for the analysis line: accept, gather, multiply-accumulate, emit.
module dpal_ctrl import dpal_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  dpal_status_t status,
  output dpal_cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_CHECK   = 4'd1;
  localparam logic [3:0] ST_GATHER  = 4'd2;
  localparam logic [3:0] ST_DRAIN   = 4'd3;
  localparam logic [3:0] ST_MUL     = 4'd4;
  localparam logic [3:0] ST_SUM1    = 4'd5;
  localparam logic [3:0] ST_SUM2    = 4'd6;
  localparam logic [3:0] ST_EMIT_LO = 4'd7;
  localparam logic [3:0] ST_EMIT_HI = 4'd8;
  localparam logic [3:0] ST_TRAIL   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.out_sel = OUT_LO;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.pair_pending) begin
          cmd.pair_init = 1'b1;
          state_next    = ST_GATHER;
        end else if (status.trailing) begin
          state_next = ST_TRAIL;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_GATHER: begin
        cmd.gather = 1'b1;
        if (status.gather_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_MUL;
      ST_MUL:   state_next = ST_SUM1;
      ST_SUM1:  state_next = ST_SUM2;
      ST_SUM2:  state_next = ST_EMIT_LO;
      ST_EMIT_LO: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = OUT_LO;
          state_next   = ST_EMIT_HI;
        end
      end
      ST_EMIT_HI: begin
        if (status.out_free) begin
          cmd.load_out  = 1'b1;
          cmd.out_sel   = OUT_HI;
          cmd.next_pair = 1'b1;
          state_next    = ST_CHECK;
        end
      end
      ST_TRAIL: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = OUT_TRAIL;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### sv/dpal_datapath.sv
// Config registers, sample stores, operand lanes, MAC arrays and output register.
`include "dwt_periodic_analysis_line_macros.svh"
module dpal_datapath import dpal_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  dpal_cmd_t                      cmd,
  output dpal_status_t                   status,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           cfg_valid,
  input  logic [CFG_INDEX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data,
  input  logic                           m_axis_tready,
  output logic                           out_valid,
  output logic signed [COEF_W-1:0]       out_coef,
  output logic [BAND_W-1:0]              out_band,
  output logic [POS_W-1:0]               out_pos,
  output logic                           out_eol,
  output logic                           out_last
);

  localparam logic [1:0] FETCH_WIN  = 2'd0;
  localparam logic [1:0] FETCH_HEAD = 2'd1;
  localparam logic [1:0] FETCH_ZERO = 2'd2;

  localparam int RND_W = ACC_W + 1;
  localparam int Q_W   = RND_W - TAP_FRAC_BITS;
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(COEF_MAX);
  localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(COEF_MIN);
  localparam logic signed [RND_W-1:0] ROUND_HALF = RND_W'(1 << (TAP_FRAC_BITS - 1));

  // round half up, floor shift, saturate
  function automatic logic signed [COEF_W-1:0] scale_sat(input logic signed [ACC_W-1:0] a);
    logic signed [RND_W-1:0] v;
    logic signed [Q_W-1:0]   q;
    v = RND_W'(a) + ROUND_HALF;
    q = v[RND_W-1:TAP_FRAC_BITS];
    if (q > Q_MAX) begin
      scale_sat = COEF_W'(COEF_MAX);
    end else if (q < Q_MIN) begin
      scale_sat = COEF_W'(COEF_MIN);
    end else begin
      scale_sat = q[COEF_W-1:0];
    end
  endfunction

  // configuration
  logic [TAP_CNT_W-1:0]  tap_count;
  logic [LEN_W-1:0]      line_length;
  logic [CFG_DATA_W-1:0] low_first, low_second, high_first, high_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count   <= TAP_CNT_W'(1);
      line_length <= LEN_W'(LINE_MAX);
      low_first   <= '0;
      low_second  <= '0;
      high_first  <= '0;
      high_second <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TAP_COUNT:        tap_count   <= cfg_data[TAP_CNT_W-1:0];
        REG_LINE_LENGTH:      line_length <= cfg_data[LEN_W-1:0];
        REG_LOW_TAPS_FIRST:   low_first   <= cfg_data;
        REG_LOW_TAPS_SECOND:  low_second  <= cfg_data;
        REG_HIGH_TAPS_FIRST:  high_first  <= cfg_data;
        REG_HIGH_TAPS_SECOND: high_second <= cfg_data;
        default: begin end
      endcase
    end
  end

  logic [2*CFG_DATA_W-1:0] low_bank, high_bank;
  assign low_bank  = {low_second, low_first};
  assign high_bank = {high_second, high_first};

  logic [TAP_CNT_W-1:0] taps_eff;
  logic [LEN_W-1:0]     len_eff;
  logic [LEN_W-1:0]     lenm1;
  logic [POS_W-1:0]     half;

  always_comb begin
    if (tap_count == '0) begin
      taps_eff = TAP_CNT_W'(1);
    end else if (tap_count > TAP_CNT_W'(MAX_TAPS)) begin
      taps_eff = TAP_CNT_W'(MAX_TAPS);
    end else begin
      taps_eff = tap_count;
    end
    if (line_length < LEN_W'(2)) begin
      len_eff = LEN_W'(2);
    end else if (line_length > LEN_W'(LINE_MAX)) begin
      len_eff = LEN_W'(LINE_MAX);
    end else begin
      len_eff = line_length;
    end
  end

  assign lenm1 = len_eff - LEN_W'(1);
  assign half  = len_eff[LEN_W-1:1];

  // per-sample plan
  logic [POS_W-1:0] sample_position;
  logic [POS_W-1:0] cur_c;
  logic             eol_c;
  logic [LEN_W-1:0] nxt, diff, span;
  logic             mid_ok;
  logic [POS_W-1:0] i0;

  always_comb begin
    cur_c  = ({1'b0, sample_position} > lenm1) ? lenm1[POS_W-1:0] : sample_position;
    eol_c  = ({1'b0, cur_c} == lenm1);
    nxt    = {1'b0, cur_c} + LEN_W'(1);
    diff   = nxt - LEN_W'(taps_eff);
    mid_ok = (nxt >= LEN_W'(taps_eff)) && !diff[0];
    span   = len_eff - LEN_W'(taps_eff) + LEN_W'(1);
    i0     = (len_eff > LEN_W'(taps_eff)) ? span[LEN_W-1:1] : '0;
  end

  logic [POS_W-1:0] pair_i, pair_end;
  logic             eol_flag, trailing;
  logic             last_pair;

  assign last_pair = (LEN_W'(pair_i) + LEN_W'(1)) == LEN_W'(pair_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_position <= '0;
      pair_i          <= '0;
      pair_end        <= '0;
      eol_flag        <= 1'b0;
      trailing        <= 1'b0;
    end else if (cmd.accept) begin
      eol_flag <= eol_c;
      trailing <= eol_c & len_eff[0];
      if (eol_c) begin
        sample_position <= '0;
        pair_i          <= i0;
        pair_end        <= half;
      end else begin
        sample_position <= nxt[POS_W-1:0];
        pair_i          <= diff[LEN_W-1:1];
        pair_end        <= mid_ok ? diff[LEN_W-1:1] + POS_W'(1) : diff[LEN_W-1:1];
      end
    end else if (cmd.next_pair) begin
      pair_i <= pair_i + POS_W'(1);
    end
  end

  // sample stores and serial gather
  logic signed [SAMPLE_WIDTH-1:0] head_samples  [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] recent_window [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] hold_sample;
  logic [POS_W-1:0]               cur;
  logic [POS_W-1:0]               p, p_wrap;
  logic [LEN_W-1:0]               p_ext;
  logic [TAP_IDX_W-1:0]           rj, cap_j;
  logic                           cap_valid;
  logic signed [SAMPLE_WIDTH-1:0] rd_win, rd_head, cap_val;
  logic [1:0]                     rd_sel, fetch_sel;
  logic signed [SAMPLE_WIDTH-1:0] op [MAX_TAPS];

  assign p_ext  = {1'b0, p};
  assign p_wrap = (p_ext + LEN_W'(1) == len_eff) ? '0 : p + POS_W'(1);

  always_comb begin
    if ((p <= cur) && ((p_ext + LEN_W'(MAX_TAPS)) > {1'b0, cur})) begin
      fetch_sel = FETCH_WIN;
    end else if (p < POS_W'(MAX_TAPS)) begin
      fetch_sel = FETCH_HEAD;
    end else begin
      fetch_sel = FETCH_ZERO;
    end
    case (rd_sel)
      FETCH_WIN:  cap_val = rd_win;
      FETCH_HEAD: cap_val = rd_head;
      default:    cap_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_valid <= 1'b0;
    end else begin
      cap_valid <= cmd.gather;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (cur_c < POS_W'(MAX_TAPS)) begin
        head_samples[cur_c[TAP_IDX_W-1:0]] <= sample;
      end
      recent_window[cur_c[TAP_IDX_W-1:0]] <= sample;
      cur         <= cur_c;
      hold_sample <= sample;
    end
    if (cmd.pair_init) begin
      p  <= {pair_i[POS_W-2:0], 1'b0};
      rj <= '0;
    end else if (cmd.gather) begin
      rd_win  <= recent_window[p[TAP_IDX_W-1:0]];
      rd_head <= head_samples[p[TAP_IDX_W-1:0]];
      rd_sel  <= fetch_sel;
      cap_j   <= rj;
      p       <= p_wrap;
      rj      <= rj + TAP_IDX_W'(1);
    end
    if (cap_valid) begin
      op[cap_j] <= cap_val;
    end
  end

  // tap-parallel multiply, then two registered add levels
  logic signed [PROD_W-1:0] prod_lo [MAX_TAPS];
  logic signed [PROD_W-1:0] prod_hi [MAX_TAPS];
  logic signed [S1_W-1:0]   s1_lo [HALF_TAPS];
  logic signed [S1_W-1:0]   s1_hi [HALF_TAPS];
  logic signed [ACC_W-1:0]  acc_lo, acc_hi, acc_lo_c, acc_hi_c;

  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_lane
    logic signed [TAP_W-1:0]  tap_lo, tap_hi;
    logic signed [PROD_W-1:0] mul_lo, mul_hi;
    logic                     lane_on;
    assign tap_lo  = low_bank[j*TAP_W +: TAP_W];
    assign tap_hi  = high_bank[j*TAP_W +: TAP_W];
    assign mul_lo  = tap_lo * op[j];
    assign mul_hi  = tap_hi * op[j];
    assign lane_on = TAP_CNT_W'(j) < taps_eff;
    always_ff @(posedge clk) begin
      prod_lo[j] <= lane_on ? mul_lo : '0;
      prod_hi[j] <= lane_on ? mul_hi : '0;
    end
  end

  for (genvar k = 0; k < HALF_TAPS; k++) begin : g_pair_sum
    always_ff @(posedge clk) begin
      s1_lo[k] <= S1_W'(prod_lo[2*k]) + S1_W'(prod_lo[2*k+1]);
      s1_hi[k] <= S1_W'(prod_hi[2*k]) + S1_W'(prod_hi[2*k+1]);
    end
  end

  always_comb begin
    acc_lo_c = '0;
    acc_hi_c = '0;
    for (int k = 0; k < HALF_TAPS; k++) begin
      acc_lo_c = acc_lo_c + ACC_W'(s1_lo[k]);
      acc_hi_c = acc_hi_c + ACC_W'(s1_hi[k]);
    end
  end

  always_ff @(posedge clk) begin
    acc_lo <= acc_lo_c;
    acc_hi <= acc_hi_c;
  end

  // output register
  logic signed [COEF_W-1:0] sel_coef;
  logic [BAND_W-1:0]        sel_band;
  logic [POS_W-1:0]         sel_pos;
  logic                     sel_eol, sel_last, run_done;

  assign run_done = last_pair & ~trailing;

  always_comb begin
    case (cmd.out_sel)
      OUT_LO: begin
        sel_coef = scale_sat(acc_lo);
        sel_band = BAND_LOW;
        sel_pos  = pair_i;
        sel_eol  = 1'b0;
        sel_last = 1'b0;
      end
      OUT_HI: begin
        sel_coef = scale_sat(acc_hi);
        sel_band = BAND_HIGH;
        sel_pos  = pair_i + half;
        sel_eol  = run_done & eol_flag;
        sel_last = run_done;
      end
      default: begin
        sel_coef = COEF_W'(hold_sample);
        sel_band = BAND_PASS;
        sel_pos  = lenm1[POS_W-1:0];
        sel_eol  = 1'b1;
        sel_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_coef <= sel_coef;
      out_band <= sel_band;
      out_pos  <= sel_pos;
      out_eol  <= sel_eol;
      out_last <= sel_last;
    end
  end

  assign status.pair_pending = pair_i < pair_end;
  assign status.trailing     = trailing;
  assign status.gather_last  = (TAP_CNT_W'(rj) == taps_eff - TAP_CNT_W'(1));
  assign status.out_free     = ~out_valid | m_axis_tready;

  `DPAL_NEVER(a_load_over_pending, cmd.load_out && out_valid && !m_axis_tready, "result loaded over a waiting beat")
  `DPAL_ASSERT(a_gather_in_line, cmd.gather |-> (p_ext < len_eff), "gather position past line end")
  `DPAL_ASSERT(a_gather_in_taps, cmd.gather |-> (TAP_CNT_W'(rj) < taps_eff), "gather lane past tap count")
  `DPAL_ASSERT(a_trail_odd, (cmd.load_out && (cmd.out_sel == OUT_TRAIL)) |-> len_eff[0], "pass-through on even line")
  `DPAL_ASSERT(a_pair_in_range, cmd.next_pair |-> (pair_i < pair_end), "pair advanced past plan")

endmodule

### sv/dwt_periodic_analysis_line.sv
// Top level of the one-level periodic wavelet analysis line.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: sample
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: coefficient, position;
//                                              tuser: band, last_of_run; tlast: end_of_line
//  cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
// A sample that completes no pair is only stored and checked; one that completes a pair
// is followed by an operand gather, the multiply, the adds and the emit of a low and a
// high coefficient. The last sample also runs this for each wrapped pair and then emits
// a passed sample on odd lines. The pace is set by the serial operand gather, one read
// of the sample stores per tap, ahead of the tap-parallel multiply and two add stages.
// The sample stores need no clearing; a new sample is taken only in idle. A stalled
// result beat holds the sequencer, but the next sample is taken while that beat waits.
module dwt_periodic_analysis_line import dpal_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] sample
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [19:0] coefficient, [29:20] position
  output logic                   m_axis_tlast,
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // [1:0] band, [2] last_of_run
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  dpal_cmd_t                cmd;
  dpal_status_t             status;
  logic signed [COEF_W-1:0] out_coef;
  logic [BAND_W-1:0]        out_band;
  logic [POS_W-1:0]         out_pos;
  logic                     out_eol;
  logic                     out_last;

  dpal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  dpal_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .sample        ($signed(s_axis_tdata[SAMPLE_WIDTH-1:0])),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .m_axis_tready (m_axis_tready),
    .out_valid     (m_axis_tvalid),
    .out_coef      (out_coef),
    .out_band      (out_band),
    .out_pos       (out_pos),
    .out_eol       (out_eol),
    .out_last      (out_last)
  );

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = {OUT_PAD_W'(0), out_pos, out_coef};
  assign m_axis_tuser = {out_last, out_band};
  assign m_axis_tlast = out_eol;

endmodule
